FILE: hdl/vt4_pkg.sv
// vt4_pkg: payload structs, field widths and constants for vertex_transform_4x4
// no dependencies; imported by every module of the block

package vt4_pkg;

  localparam int unsigned COMP_W   = 16;
  localparam int unsigned ROW_W    = 4 * COMP_W;
  localparam int unsigned LANES    = 4;
  localparam int unsigned PROD_W   = 2 * COMP_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned FRAC_SH  = 12;
  localparam int unsigned TRUNC_W  = SUM_W - FRAC_SH;
  localparam int unsigned IDX_W    = 2;

  localparam logic signed [COMP_W-1:0] ONE_Q8_8 = 16'sd256;

  localparam logic [IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROW2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_ROW3 = 2'd3;

  localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic  mode;
    comp_t in_x;
    comp_t in_y;
    comp_t in_z;
    comp_t in_w;
  } vt4_in_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    comp_t out_w;
    logic  saturated;
  } vt4_out_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctl_t;

endpackage

FILE: hdl/vt4_lane.sv
// vt4_lane: one matrix row dot product, registered products then registered
// sum, truncation to Q8.8 and saturation; uses vt4_pkg

module vt4_lane
  import vt4_pkg::*;
(
  input  logic             clk,
  input  lane_ctl_t        ctl,
  input  logic [ROW_W-1:0] coefs,
  input  comp_t            vec [LANES],
  output comp_t            result,
  output logic             sat
);

  logic signed [PROD_W-1:0]  prod [LANES];
  logic signed [SUM_W-1:0]   sum;
  logic signed [TRUNC_W-1:0] trunc;
  logic                      over_hi;
  logic                      over_lo;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      for (int j = 0; j < LANES; j++) begin
        prod[j] <= $signed(coefs[j*COMP_W +: COMP_W]) * vec[j];
      end
    end
  end

  always_comb begin
    sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
    trunc = sum[SUM_W-1:FRAC_SH];
    over_hi = !trunc[TRUNC_W-1] && (trunc[TRUNC_W-2:COMP_W-1] != '0);
    over_lo = trunc[TRUNC_W-1] && (trunc[TRUNC_W-2:COMP_W-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      sat <= over_hi || over_lo;
      if (over_hi) begin
        result <= {1'b0, {(COMP_W-1){1'b1}}};
      end else if (over_lo) begin
        result <= {1'b1, {(COMP_W-1){1'b0}}};
      end else begin
        result <= trunc[COMP_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/vt4_merge.sv
// vt4_merge: combines the four lane results and flags into the output beat
// register with its handshake; uses vt4_pkg

module vt4_merge
  import vt4_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     lane_valid,
  output logic     lane_ready,
  input  comp_t    lane_result [LANES],
  input  logic     lane_sat [LANES],
  output logic     out_valid,
  input  logic     out_ready,
  output vt4_out_t out_data
);

  assign lane_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lane_ready) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready) begin
      out_data.out_x     <= lane_result[0];
      out_data.out_y     <= lane_result[1];
      out_data.out_z     <= lane_result[2];
      out_data.out_w     <= lane_result[3];
      out_data.saturated <= lane_sat[0] | lane_sat[1] | lane_sat[2] | lane_sat[3];
    end
  end

endmodule

FILE: hdl/vertex_transform_4x4.sv
// channel   dir  handshake                 payload
// in        in   in_valid / in_ready       in_data  (mode, in_x..in_w)
// out       out  out_valid / out_ready     out_data (out_x..out_w, saturated)
// cfg       in   cfg_we                    cfg_index, cfg_data (row0..row3)
//
// one vertex per clock unless out_ready stalls the output
// stages: products, row sums with saturation, output register
// each stage refills when the next one moves, so bubbles are squeezed out
// sync reset clears stage valids and loads the identity matrix
// top level of the block; uses vt4_pkg, vt4_lane, vt4_merge

module vertex_transform_4x4
  import vt4_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vt4_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vt4_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0] cfg_data
);

  logic [ROW_W-1:0] rows [LANES];
  logic             mul_valid;
  logic             sum_valid;
  logic             sum_ready;
  logic             merge_ready;
  lane_ctl_t        ctl;
  comp_t            vec [LANES];
  comp_t            lane_result [LANES];
  logic             lane_sat [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW0_RST;
      rows[1] <= ROW1_RST;
      rows[2] <= ROW2_RST;
      rows[3] <= ROW3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW0: rows[0] <= cfg_data;
        REG_ROW1: rows[1] <= cfg_data;
        REG_ROW2: rows[2] <= cfg_data;
        REG_ROW3: rows[3] <= cfg_data;
        default:  rows[0] <= rows[0];
      endcase
    end
  end

  assign sum_ready = !sum_valid || merge_ready;
  assign in_ready  = !mul_valid || sum_ready;
  assign ctl.en_mul = in_ready;
  assign ctl.en_sum = sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mul_valid <= in_valid;
      end
      if (sum_ready) begin
        sum_valid <= mul_valid;
      end
    end
  end

  always_comb begin
    vec[0] = in_data.in_x;
    vec[1] = in_data.in_y;
    vec[2] = in_data.in_z;
    vec[3] = in_data.mode ? ONE_Q8_8 : in_data.in_w;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vt4_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .coefs  (rows[i]),
      .vec    (vec),
      .result (lane_result[i]),
      .sat    (lane_sat[i])
    );
  end

  vt4_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .lane_valid  (sum_valid),
    .lane_ready  (merge_ready),
    .lane_result (lane_result),
    .lane_sat    (lane_sat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: hdl/vt4_checker.sv
// vt4_checker: port-level assertions for vertex_transform_4x4
// uses vt4_pkg; bound to the top level below

module vt4_checker
  import vt4_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input vt4_out_t out_data
);

  localparam comp_t MAX_Q = 16'sh7fff;
  localparam comp_t MIN_Q = 16'sh8000;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled output payload changed");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_x != MAX_Q && out_data.out_x != MIN_Q
      && out_data.out_y != MAX_Q && out_data.out_y != MIN_Q
      && out_data.out_z != MAX_Q && out_data.out_z != MIN_Q
      && out_data.out_w != MAX_Q && out_data.out_w != MIN_Q
      |-> !out_data.saturated)
    else $error("saturated set with no clipped component");

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench for vertex_transform_4x4: drives vertices and matrix rows, compares every
// output beat with a given or a computed fixed-point result; uses vt4_pkg and the rtl

module testbench;
  import vt4_pkg::*;

  typedef enum {MAT_WIDE, MAT_NARROW, MAT_MAX, MAT_MIN, MAT_ZERO, MAT_IDENT} mat_kind_t;

  typedef struct {
    bit               is_cfg;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] row;
    vt4_in_t          vtx;
    bit               known;
    vt4_out_t         want;
  } step_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  vt4_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  vt4_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;

  logic [ROW_W-1:0] matrix_rows [LANES];
  logic [ROW_W-1:0] identity_rows [LANES];
  vt4_out_t         awaited_vertices [$];
  step_t            directed_steps [$];
  int               failures = 0;
  int               vertex_beats = 0;
  bit               valid_up = 1'b0;
  bit               squeeze = 1'b0;
  bit               calm = 1'b0;

  vertex_transform_4x4 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic vt4_out_t transform_vertex(input vt4_in_t v);
    longint           comp [LANES];
    longint           acc;
    logic [COMP_W-1:0] lane_out [LANES];
    logic             clipped;
    comp[0] = longint'(v.in_x);
    comp[1] = longint'(v.in_y);
    comp[2] = longint'(v.in_z);
    comp[3] = v.mode ? longint'(ONE_Q8_8) : longint'(v.in_w);
    clipped = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      acc = 0;
      for (int j = 0; j < LANES; j++)
        acc += longint'($signed(matrix_rows[i][COMP_W*j +: COMP_W])) * comp[j];
      acc = acc >>> FRAC_SH;
      if (acc > 32767) begin
        acc = 32767;
        clipped = 1'b1;
      end else if (acc < -32768) begin
        acc = -32768;
        clipped = 1'b1;
      end
      lane_out[i] = acc[COMP_W-1:0];
    end
    return {lane_out[0], lane_out[1], lane_out[2], lane_out[3], clipped};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (squeeze || calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 2);
    return $urandom_range(5, 20);
  endfunction

  function automatic comp_t random_comp(input int style);
    logic [31:0] r;
    case (style)
      0: r = $urandom_range(0, 32'h2000) - 32'h1000;
      1: r = $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: r = 32'h7FFF;
          1: r = 32'h8000;
          2: r = 32'h0000;
          3: r = 32'hFFFF;
          default: r = 32'h0001;
        endcase
      end
    endcase
    return r[COMP_W-1:0];
  endfunction

  function automatic vt4_in_t random_vertex();
    vt4_in_t v;
    int      r;
    int      style;
    r = $urandom_range(0, 9);
    style = (r < 5) ? 0 : (r < 8) ? 1 : 2;
    v.mode = 1'($urandom_range(0, 1));
    v.in_x = random_comp(style);
    v.in_y = random_comp(style);
    v.in_z = random_comp(style);
    v.in_w = random_comp(style);
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] make_row(input mat_kind_t kind,
                                                input logic [IDX_W-1:0] idx);
    logic [ROW_W-1:0] r;
    logic [31:0]      c;
    r = '0;
    case (kind)
      MAT_WIDE:   r = {$urandom, $urandom};
      MAT_NARROW: begin
        for (int j = 0; j < LANES; j++) begin
          c = $urandom_range(0, 32'h4000) - 32'h2000;
          r[COMP_W*j +: COMP_W] = c[COMP_W-1:0];
        end
      end
      MAT_MAX:    r = {LANES{16'h7FFF}};
      MAT_MIN:    r = {LANES{16'h8000}};
      MAT_ZERO:   r = '0;
      default:    r = identity_rows[idx];
    endcase
    return r;
  endfunction

  function automatic void add_cfg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] row);
    step_t s;
    s = '{is_cfg: 1'b1, idx: idx, row: row, vtx: '0, known: 1'b0, want: '0};
    directed_steps.push_back(s);
  endfunction

  function automatic void add_vtx(input logic m, input comp_t x, input comp_t y,
                                  input comp_t z, input comp_t w);
    step_t s;
    s = '{is_cfg: 1'b0, idx: '0, row: '0, vtx: {m, x, y, z, w}, known: 1'b0, want: '0};
    directed_steps.push_back(s);
  endfunction

  function automatic void add_known(input logic m, input comp_t x, input comp_t y,
                                    input comp_t z, input comp_t w,
                                    input comp_t ox, input comp_t oy, input comp_t oz,
                                    input comp_t ow, input logic sat);
    step_t s;
    s = '{is_cfg: 1'b0, idx: '0, row: '0, vtx: {m, x, y, z, w}, known: 1'b1,
          want: {ox, oy, oz, ow, sat}};
    directed_steps.push_back(s);
  endfunction

  task automatic send_vertex(input vt4_in_t v, input bit known, input vt4_out_t want);
    int gap;
    in_valid <= 1'b1;
    in_data  <= v;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    awaited_vertices.push_back(known ? want : transform_vertex(v));
    vertex_beats++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (awaited_vertices.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    matrix_rows[idx] = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : out_check
    vt4_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_vertices.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected output beat %h", out_data);
      end else begin
        want = awaited_vertices.pop_front();
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.out_z !== want.out_z || out_data.out_w !== want.out_w ||
            out_data.saturated !== want.saturated) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
                     want.out_x, want.out_y, want.out_z, want.out_w, want.saturated,
                     out_data.out_x, out_data.out_y, out_data.out_z, out_data.out_w,
                     out_data.saturated);
        end
      end
    end
  end

  initial begin : sink_side
    int stall;
    int r;
    int long_holds;
    long_holds = 0;
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (long_holds < 2 && vertex_beats >= 400 + 500 * long_holds) begin
        long_holds++;
        squeeze = 1'b1;
        stall = 150;
      end else if (r < 55) begin
        stall = 0;
      end else if (r < 90) begin
        stall = $urandom_range(1, 3);
      end else begin
        stall = $urandom_range(8, 30);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      squeeze = 1'b0;
      out_ready <= 1'b1;
      r = $urandom_range(0, 99);
      repeat ((r < 10) ? $urandom_range(40, 120) : $urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : source_side
    mat_kind_t kind;
    identity_rows[REG_ROW0] = ROW0_RST;
    identity_rows[REG_ROW1] = ROW1_RST;
    identity_rows[REG_ROW2] = ROW2_RST;
    identity_rows[REG_ROW3] = ROW3_RST;
    matrix_rows = identity_rows;

    // identity after reset, point mode forces w to one
    add_known(1'b0, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
              16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 1'b0);
    add_known(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
              16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 1'b0);
    add_known(1'b1, 16'h0100, 16'hFF00, 16'h0000, 16'h7FFF,
              16'h0100, 16'hFF00, 16'h0000, 16'h0100, 1'b0);
    add_known(1'b1, 16'h8000, 16'h7FFF, 16'h1234, 16'h8000,
              16'h8000, 16'h7FFF, 16'h1234, 16'h0100, 1'b0);
    add_known(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    // half on x: truncation rounds toward minus infinity
    add_cfg(REG_ROW0, 64'h0000_0000_0000_0800);
    add_known(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
              16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_known(1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_known(1'b0, 16'hFFFD, 16'h0002, 16'h0003, 16'h0004,
              16'hFFFE, 16'h0002, 16'h0003, 16'h0004, 1'b0);
    // largest coefficients
    add_cfg(REG_ROW0, {LANES{16'h7FFF}});
    add_cfg(REG_ROW1, {LANES{16'h7FFF}});
    add_cfg(REG_ROW2, {LANES{16'h7FFF}});
    add_cfg(REG_ROW3, {LANES{16'h7FFF}});
    add_known(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    add_known(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    add_known(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_vtx(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    // most negative coefficients
    add_cfg(REG_ROW0, {LANES{16'h8000}});
    add_cfg(REG_ROW1, {LANES{16'h8000}});
    add_cfg(REG_ROW2, {LANES{16'h8000}});
    add_cfg(REG_ROW3, {LANES{16'h8000}});
    add_known(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    add_known(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    add_vtx(1'b1, 16'h7FFF, 16'h0000, 16'h8000, 16'h1234);
    // sum row, negate row, zero row, identity row: saturation boundaries
    add_cfg(REG_ROW0, {LANES{16'h1000}});
    add_cfg(REG_ROW1, 64'h0000_0000_0000_F000);
    add_cfg(REG_ROW2, 64'h0000_0000_0000_0000);
    add_cfg(REG_ROW3, ROW3_RST);
    add_known(1'b0, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000,
              16'h7FFF, 16'h8001, 16'h0000, 16'h0000, 1'b1);
    add_known(1'b0, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
              16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
    add_known(1'b0, 16'hC000, 16'hC000, 16'h0000, 16'h0000,
              16'h8000, 16'h4000, 16'h0000, 16'h0000, 1'b0);
    add_known(1'b0, 16'h4000, 16'h3FFF, 16'h0000, 16'h0000,
              16'h7FFF, 16'hC000, 16'h0000, 16'h0000, 1'b0);
    add_vtx(1'b1, 16'h0123, 16'hFEDC, 16'h4000, 16'h0000);
    add_vtx(1'b0, 16'h1357, 16'h9BDF, 16'h2468, 16'hACE0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[k]) begin
      if (directed_steps[k].is_cfg)
        load_row(directed_steps[k].idx, directed_steps[k].row);
      else
        send_vertex(directed_steps[k].vtx, directed_steps[k].known, directed_steps[k].want);
    end

    for (int phase = 0; phase < 12; phase++) begin
      kind = (phase % 2) ? MAT_NARROW : mat_kind_t'((phase / 2) % 6);
      load_row(REG_ROW0, make_row(kind, REG_ROW0));
      load_row(REG_ROW1, make_row(kind, REG_ROW1));
      load_row(REG_ROW2, make_row(kind, REG_ROW2));
      load_row(REG_ROW3, make_row(kind, REG_ROW3));
      for (int n = 0; n < 105; n++) begin
        calm = (n >= 40 && n < 65);
        send_vertex(random_vertex(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (awaited_vertices.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/vt4_pkg.sv
hdl/vt4_lane.sv
hdl/vt4_merge.sv
hdl/vertex_transform_4x4.sv
hdl/vt4_checker.sv
dv/testbench.sv
